@@ rtl/mqsb_pkg.sv @@
// mqsb_pkg: constants, types and helpers for the shared-buffer queue block
// no dependencies; used by the interfaces and all rtl modules
`default_nettype none

package mqsb_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int SLOTS      = 16;
    localparam int QID_W      = 2;
    localparam int DATA_W     = 32;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int PTR_W      = SLOT_W + 1;

    typedef logic [SLOT_W-1:0]        slot_t;
    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [QID_W-1:0]         qid_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [1:0]               status_t;
    typedef logic                     op_t;

    localparam ptr_t NULL_PTR = PTR_W'(SLOTS);

    localparam op_t OP_ENQ = 1'b0;
    localparam op_t OP_DEQ = 1'b1;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // one write into the link table
    typedef struct packed {
        logic  en;
        slot_t addr;
        ptr_t  data;
    } link_wr_t;

    function automatic logic is_null(input ptr_t p);
        return p >= NULL_PTR;
    endfunction

    function automatic logic q_present(input qid_t q);
        return 32'(q) < NUM_QUEUES;
    endfunction

    // link table value after reset: next slot, last one null
    function automatic ptr_t link_init(input slot_t s);
        return PTR_W'(s) + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/mqsb_req_if.sv @@
// mqsb_req_if: request channel (operation, queue number, data)
// depends on mqsb_pkg
`default_nettype none

interface mqsb_req_if;
    import mqsb_pkg::*;

    logic  valid;
    logic  ready;
    op_t   op;
    qid_t  queue_id;
    data_t data_in;

    modport source (output valid, output op, output queue_id, output data_in, input ready);
    modport sink   (input valid, input op, input queue_id, input data_in, output ready);
endinterface

`default_nettype wire

@@ rtl/mqsb_rsp_if.sv @@
// mqsb_rsp_if: response channel (data, status)
// depends on mqsb_pkg
`default_nettype none

interface mqsb_rsp_if;
    import mqsb_pkg::*;

    logic    valid;
    logic    ready;
    data_t   data_out;
    status_t status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink   (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/mqsb_link_store.sv @@
// mqsb_link_store: next-pointer table, one write and one registered read per cycle
// depends on mqsb_pkg; unwritten entries read as their reset value via valid bits
`default_nettype none

module mqsb_link_store
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire mqsb_pkg::slot_t   rd_addr,
    input  wire mqsb_pkg::link_wr_t wr,
    output mqsb_pkg::ptr_t         rd_data
);
    import mqsb_pkg::*;

    ptr_t             mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    ptr_t             mem_q_reg;
    ptr_t             alt_reg;
    logic             use_mem_reg;
    logic             bypass;

    assign bypass = wr.en && (wr.addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg   <= mem[rd_addr];
            // same-cycle write wins over the stored copy
            alt_reg     <= bypass ? wr.data : link_init(rd_addr);
            use_mem_reg <= !bypass && valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = use_mem_reg ? mem_q_reg : alt_reg;

endmodule

`default_nettype wire

@@ rtl/multi_queue_shared_buffer.sv @@
// multi_queue_shared_buffer: several fifo queues linked through one shared slot store
// depends on mqsb_pkg, mqsb_req_if, mqsb_rsp_if and mqsb_link_store
//
//   channel | dir | payload                     | per item
//   --------+-----+-----------------------------+---------------------------
//   req     | in  | op, queue_id, data_in       | one operation
//   rsp     | out | data_out, status            | one result per operation
//
// one item per cycle when rsp is not stalled; rsp valid is registered after req
// acceptance (memory read at acceptance, update and result when the item fires)
// reset: all queues empty, every slot on the free list, no clearing pass
// a stalled rsp holds the item in the execute stage and req ready drops
// only after both the execute stage and the result register are full
`default_nettype none

module multi_queue_shared_buffer
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mqsb_req_if.sink    req,
    mqsb_rsp_if.source  rsp
);
    import mqsb_pkg::*;

    // queue pointers and free list head
    ptr_t  head_reg [NUM_QUEUES];
    ptr_t  head_next [NUM_QUEUES];
    slot_t tail_reg [NUM_QUEUES];
    slot_t tail_next [NUM_QUEUES];
    ptr_t  free_head_reg;
    ptr_t  free_head_next;

    // execute stage, loaded at acceptance together with the memory reads
    logic  s1_valid_reg;
    op_t   s1_op_reg;
    qid_t  s1_q_reg;
    data_t s1_din_reg;

    // slot data store with registered read and same-cycle bypass
    data_t slot_mem [SLOTS];
    data_t slot_q_reg;
    data_t slot_wd_reg;
    logic  slot_byp_reg;
    data_t slot_rd;
    logic  slot_we;
    slot_t slot_waddr;

    // result register
    logic    out_valid_reg;
    data_t   out_data_reg;
    status_t out_status_reg;

    logic     accept;
    logic     fire;
    logic     enq_ok;
    logic     deq_ok;
    ptr_t     head_cur;
    ptr_t     link_rd;
    ptr_t     rd_ptr;
    slot_t    rd_idx;
    link_wr_t link_wr;
    data_t    res_data;
    status_t  res_status;

    assign fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign accept = req.valid && req.ready;
    assign req.ready = !s1_valid_reg || fire;

    assign head_cur = head_reg[s1_q_reg];
    assign enq_ok   = (s1_op_reg == OP_ENQ) && q_present(s1_q_reg) && !is_null(free_head_reg);
    assign deq_ok   = (s1_op_reg == OP_DEQ) && q_present(s1_q_reg) && !is_null(head_cur);
    assign slot_rd  = slot_byp_reg ? slot_wd_reg : slot_q_reg;

    // state update for the item in the execute stage; link_rd holds the
    // link of the free head (enqueue) or of the queue head (dequeue)
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        link_wr        = '0;
        slot_we        = 1'b0;
        slot_waddr     = free_head_reg[SLOT_W-1:0];
        res_data       = '0;
        res_status     = ST_OK;

        if (s1_op_reg == OP_ENQ)
        begin
            if (!enq_ok)
            begin
                res_status = ST_FULL;
            end
            else if (fire)
            begin
                free_head_next = link_rd;
                if (is_null(head_cur))
                begin
                    head_next[s1_q_reg] = free_head_reg;
                end
                else
                begin
                    // append after the current tail
                    link_wr.en   = 1'b1;
                    link_wr.addr = tail_reg[s1_q_reg];
                    link_wr.data = free_head_reg;
                end
                tail_next[s1_q_reg] = free_head_reg[SLOT_W-1:0];
                slot_we = 1'b1;
            end
        end
        else
        begin
            if (!deq_ok)
            begin
                res_status = ST_EMPTY;
            end
            else
            begin
                res_data = slot_rd;
                if (fire)
                begin
                    // the tail's link is never written, so the tail test ends the list
                    head_next[s1_q_reg] = (head_cur[SLOT_W-1:0] == tail_reg[s1_q_reg])
                                          ? NULL_PTR : link_rd;
                    link_wr.en   = 1'b1;
                    link_wr.addr = head_cur[SLOT_W-1:0];
                    link_wr.data = free_head_reg;
                    free_head_next = head_cur;
                end
            end
        end
    end

    // read address for the incoming item sees the update of the item ahead
    assign rd_ptr = (req.op == OP_DEQ) ? head_next[req.queue_id] : free_head_next;
    assign rd_idx = rd_ptr[SLOT_W-1:0];

    mqsb_link_store u_link
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_idx),
        .wr      (link_wr),
        .rd_data (link_rd)
    );

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= s1_din_reg;
        end
        if (accept)
        begin
            slot_q_reg   <= slot_mem[rd_idx];
            slot_wd_reg  <= s1_din_reg;
            slot_byp_reg <= slot_we && (slot_waddr == rd_idx);
            s1_op_reg    <= req.op;
            s1_q_reg     <= req.queue_id;
            s1_din_reg   <= req.data_in;
        end
        if (fire)
        begin
            out_data_reg   <= res_data;
            out_status_reg <= res_status;
        end
        tail_reg <= tail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= NULL_PTR;
            end
            free_head_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            free_head_reg <= free_head_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.data_out = out_data_reg;
    assign rsp.status   = out_status_reg;

    // a refused operation leaves the free list alone
    a_refused_keeps_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !enq_ok && !deq_ok |=> $stable(free_head_reg))
        else $error("free list changed on a refused operation");

    // a dequeued slot becomes the new free head
    a_deq_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fire && deq_ok |=> free_head_reg == $past(head_cur))
        else $error("dequeued slot not returned to free list");

    // a new result only appears after the execute stage fires
    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result without an executed item");

    // failed operations carry zero data
    a_fail_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |-> out_data_reg == '0)
        else $error("non-zero data on a failed operation");

endmodule

`default_nettype wire

@@ tb/multi_queue_shared_buffer_tb.sv @@
// multi_queue_shared_buffer_tb: self-checking bench for the shared-buffer queue block
// drives enqueue and dequeue items into req and checks every rsp item against a
// linked-list predictor; depends on mqsb_pkg, mqsb_req_if, mqsb_rsp_if and the rtl
`timescale 1ns / 100ps

module multi_queue_shared_buffer_tb;
    import mqsb_pkg::*;

    localparam int  NUM_ROWS      = 27;
    localparam int  RANDOM_ITEMS  = 400;
    localparam int  DRAIN_CYCLES  = 12;
    localparam int  LIMIT_CYCLES  = 200000;
    localparam int  MAX_REPORTS   = 10;

    // expected or observed response, tagged with the request that caused it
    typedef struct {
        op_t     op;
        qid_t    qid;
        data_t   data;
        status_t status;
    } queue_result_t;

    // one row of the directed table; checked rows carry their own answer
    typedef struct {
        op_t     op;
        qid_t    qid;
        data_t   din;
        logic    checked;
        data_t   exp_data;
        status_t exp_status;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mqsb_req_if req_ch ();
    mqsb_rsp_if rsp_ch ();

    multi_queue_shared_buffer uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // predictor copy of the linked-list state
    ptr_t  q_head    [NUM_QUEUES];
    slot_t q_tail    [NUM_QUEUES];
    ptr_t  next_slot [SLOTS];
    data_t slot_val  [SLOTS];
    ptr_t  free_top;

    queue_result_t pending_results [$];
    dir_row_t      directed_rows [NUM_ROWS];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    // all queues empty, every slot chained on the free list in order
    function automatic void clear_queue_state();
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            q_head[i] = NULL_PTR;
            q_tail[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            next_slot[i] = ptr_t'(i + 1);
            slot_val[i]  = '0;
        end
        next_slot[SLOTS-1] = NULL_PTR;
        free_top = '0;
    endfunction

    // applies one operation to the predictor state and returns its response
    function automatic queue_result_t apply_queue_op(input op_t op, input qid_t q,
                                                     input data_t din);
        queue_result_t r;
        slot_t         s;
        r.op     = op;
        r.qid    = q;
        r.data   = '0;
        r.status = ST_OK;
        if (op == OP_ENQ)
        begin
            if (int'(q) >= NUM_QUEUES || free_top >= NULL_PTR)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // pop the free list, append after the tail
                s        = slot_t'(free_top);
                free_top = next_slot[s];
                if (q_head[q] >= NULL_PTR)
                    q_head[q] = ptr_t'(s);
                else
                    next_slot[q_tail[q]] = ptr_t'(s);
                next_slot[s] = NULL_PTR;
                q_tail[q]    = s;
                slot_val[s]  = din;
            end
        end
        else
        begin
            if (int'(q) >= NUM_QUEUES || q_head[q] >= NULL_PTR)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                // unlink the head, push it back onto the free list
                s            = slot_t'(q_head[q]);
                r.data       = slot_val[s];
                q_head[q]    = next_slot[s];
                next_slot[s] = free_top;
                free_top     = ptr_t'(s);
            end
        end
        return r;
    endfunction

    // presents one item, waits for acceptance, records what should come back
    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input op_t op, input qid_t q, input data_t din,
                             input logic checked, input data_t exp_data,
                             input status_t exp_status);
        queue_result_t predicted;
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.queue_id <= q;
        req_ch.data_in  <= din;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // accepted at this edge: the predictor always advances
        predicted = apply_queue_op(op, q, din);
        if (checked)
        begin
            predicted.data   = exp_data;
            predicted.status = exp_status;
        end
        pending_results.push_back(predicted);
        @(negedge clk);
    endtask

    // bursts of back-to-back items, then a gap with valid low
    task automatic pace_sender();
        int gap;
        if (burst_left != 0)
        begin
            burst_left--;
        end
        else
        begin
            // now and then a long burst with no idling at all
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(20, 40);
            else
                burst_left = $urandom_range(0, 10);
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // receiver back-pressure: the ready pattern follows a randomly picked mode
    initial
    begin
        rx_mode_t rx_mode;
        int       rx_tick;
        rx_mode = RX_OPEN;
        rx_tick = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (rx_tick % 80 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:     rsp_ch.ready <= 1'b1;
                RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: rsp_ch.ready <= (rx_tick % 7) >= 3;
                default:     rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // response checker: every accepted rsp item against the oldest expectation
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected rsp item: data %h status %0d",
                             rsp_ch.data_out, rsp_ch.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.data_out !== want.data || rsp_ch.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch op %0d q %0d: expected data %h status %0d, got data %h status %0d",
                                 want.op, want.qid, want.data, want.status,
                                 rsp_ch.data_out, rsp_ch.status);
                end
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int   sent;
        int   phase;
        int   phase_len;
        int   enq_pct;
        op_t  op;

        // quiet inputs from time zero
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_ENQ;
        req_ch.queue_id = '0;
        req_ch.data_in  = '0;
        rst_n           = 1'b0;
        clear_queue_state();

        // directed table
        directed_rows = '{
            // dequeue from every queue straight after reset: all empty
            '{OP_DEQ, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{OP_DEQ, 2'd1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{OP_DEQ, 2'd2, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{OP_DEQ, 2'd3, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
            // most negative and most positive values round trip
            '{OP_ENQ, 2'd0, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd3, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_DEQ, 2'd3, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
            '{OP_DEQ, 2'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
            '{OP_DEQ, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
            // fill every slot, spread unevenly over the queues
            '{OP_ENQ, 2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd2, 32'h5555_5555, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd3, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd0, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd0, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd2, 32'h8000_0001, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd2, 32'h7FFF_FFFE, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd1, 32'h0F0F_0F0F, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd3, 32'hF0F0_F0F0, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd3, 32'h3333_3333, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd0, 32'hCCCC_CCCC, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd1, 32'h00FF_00FF, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd2, 32'hFF00_FF00, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd3, 32'h0000_FFFF, 1'b1, 32'h0000_0000, ST_OK},
            '{OP_ENQ, 2'd0, 32'hFFFF_0000, 1'b1, 32'h0000_0000, ST_OK},
            // store exhausted
            '{OP_ENQ, 2'd1, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, ST_FULL},
            // head of a multi-entry queue, left to the predictor
            '{OP_DEQ, 2'd2, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
        };

        // reset held low from time zero, released on a falling edge
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_item(directed_rows[i].op, directed_rows[i].qid, directed_rows[i].din,
                      directed_rows[i].checked, directed_rows[i].exp_data,
                      directed_rows[i].exp_status);
            pace_sender();
        end

        // random phases mix filling, draining and balanced phases of the store,
        // so full and empty cases keep coming round
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(30, 70);
            if (phase % 3 == 2)
                enq_pct = 50;
            else if (phase % 2 == 0)
                enq_pct = $urandom_range(5, 30);
            else
                enq_pct = $urandom_range(70, 95);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
                send_item(op, qid_t'($urandom_range(0, NUM_QUEUES - 1)),
                          data_t'($urandom), 1'b0, '0, ST_OK);
                pace_sender();
                sent++;
            end
            phase++;
        end

        // wait for every outstanding response, then a little longer
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
